// ----- design/hvn_pkg.sv -----
package hvn_pkg;

    localparam int MAX_SIDE = 128;
    localparam int CW       = 7;
    localparam int AW       = 2 * CW;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;

    localparam logic [7:0] SIDE_MIN = 8'd2;
    localparam logic [7:0] SIDE_MAX = 8'(MAX_SIDE);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] STAT_WRITE   = 2'd0;
    localparam logic [1:0] STAT_NORMAL  = 2'd1;
    localparam logic [1:0] STAT_OUTSIDE = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic [6:0]         row;
        logic [6:0]         col;
        logic signed [15:0] height;
    } t_in;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec;

    typedef struct packed {
        logic go;
        logic vert;
    } t_norm_req;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_RWAIT, S_TRI, S_TWAIT, S_VERT, S_VWAIT, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        N_IDLE, N_SQ, N_ROOT, N_DSET, N_DIV, N_DONE
    } t_nstate;

    function automatic logic signed [31:0] vec_get(input t_vec v, input logic [1:0] k);
        logic signed [31:0] r;
        case (k)
            2'd0: r = v.x;
            2'd1: r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

endpackage

// ----- design/hvn_ram.sv -----
module hvn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/hvn_norm.sv -----
module hvn_norm import hvn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_norm_req i_req,
    input  t_vec      i_vec,
    output logic      o_done,
    output t_vec      o_vec
);

    t_nstate r_state, n_state;
    t_vec        r_v;
    t_vec        r_u;
    logic        r_vert;
    logic [1:0]  r_k;
    logic [63:0] r_prod;
    logic [63:0] r_q;
    logic [63:0] r_x;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [4:0]  r_it;
    logic [31:0] r_len;
    logic [31:0] r_rem;
    logic [29:0] r_num;
    logic [29:0] r_quo;
    logic [4:0]  r_dit;

    logic signed [31:0] comp;
    logic [31:0] mag;
    logic [63:0] q_sum;
    logic [63:0] root_try;
    logic        root_ge;
    logic [63:0] res_n;
    logic [61:0] numer;
    logic [32:0] trial;
    logic        div_ge;
    logic [32:0] div_diff;
    logic [29:0] quo_n;
    logic [29:0] lim;
    logic [29:0] sat;
    logic signed [31:0] outc;

    always_comb begin
        comp     = vec_get(r_v, r_k);
        mag      = comp[31] ? 32'(-comp) : 32'(comp);
        q_sum    = r_q + r_prod;
        root_try = r_res + r_bit;
        root_ge  = r_x >= root_try;
        res_n    = root_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
        numer    = (r_vert ? (62'(mag) << 14) : (62'(mag) << 31)) + 62'(r_len >> 1);
        trial    = {r_rem, r_num[29]};
        div_ge   = trial >= {1'b0, r_len};
        div_diff = trial - {1'b0, r_len};
        quo_n    = {r_quo[28:0], div_ge};
        lim      = r_vert ? 30'd16384 : 30'(1 << 28);
        sat      = (quo_n > lim) ? lim : quo_n;
        outc     = comp[31] ? -$signed({2'b00, sat}) : $signed({2'b00, sat});
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            N_IDLE: if (i_req.go) n_state = N_SQ;
            N_SQ:   if (r_k == 2'd3) n_state = N_ROOT;
            N_ROOT: if (r_it == 5'd31) n_state = N_DSET;
            N_DSET: begin
                if (r_len == '0) begin
                    if (r_k == 2'd2) n_state = N_DONE;
                end else begin
                    n_state = N_DIV;
                end
            end
            N_DIV: begin
                if (r_dit == 5'd29) n_state = (r_k == 2'd2) ? N_DONE : N_DSET;
            end
            N_DONE: n_state = N_IDLE;
            default: n_state = N_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == N_DONE);
        o_vec  = r_u;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            N_IDLE: begin
                if (i_req.go) begin
                    r_v    <= i_vec;
                    r_vert <= i_req.vert;
                    r_k    <= '0;
                    r_q    <= '0;
                    r_prod <= '0;
                end
            end
            N_SQ: begin
                // Squares go through one registered multiplier, one component a cycle.
                r_prod <= 64'(mag) * 64'(mag);
                r_q    <= q_sum;
                r_k    <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_x   <= r_vert ? q_sum : (q_sum << 6);
                    r_res <= '0;
                    r_bit <= 64'(1) << 62;
                    r_it  <= '0;
                end
            end
            N_ROOT: begin
                if (root_ge) begin
                    r_x <= r_x - root_try;
                end
                r_res <= res_n;
                r_bit <= r_bit >> 2;
                r_it  <= r_it + 5'd1;
                if (r_it == 5'd31) begin
                    r_len <= 32'(res_n);
                    r_k   <= '0;
                end
            end
            N_DSET: begin
                if (r_len == '0) begin
                    case (r_k)
                        2'd0: r_u.x <= '0;
                        2'd1: r_u.y <= '0;
                        default: r_u.z <= '0;
                    endcase
                    r_k <= r_k + 2'd1;
                end else begin
                    // The quotient stays below 2^30, so the top part is already below len.
                    r_rem <= numer[61:30];
                    r_num <= numer[29:0];
                    r_quo <= '0;
                    r_dit <= '0;
                end
            end
            N_DIV: begin
                r_rem <= div_ge ? div_diff[31:0] : trial[31:0];
                r_num <= {r_num[28:0], 1'b0};
                r_quo <= quo_n;
                r_dit <= r_dit + 5'd1;
                if (r_dit == 5'd29) begin
                    case (r_k)
                        2'd0: r_u.x <= outc;
                        2'd1: r_u.y <= outc;
                        default: r_u.z <= outc;
                    endcase
                    r_k <= r_k + 2'd1;
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- design/heightmap_vertex_normals_unit.sv -----
// Height-grid vertex normal unit. A write transfer stores one Q8.8 height at (row, col) and
// returns status 0 in the next cycle. A query transfer reads the 3x3 neighborhood from the
// height RAM, then normalizes each existing triangle normal and finally their sum in one shared
// normalizer (a 32-step square root and three 30-step divisions per normalization), up to
// seven per query for an interior vertex and fewer at edges and corners. Coordinates outside
// the grid return status 2 at once. The input is taken only while the block is idle and its
// output register is free to load.
module heightmap_vertex_normals_unit import hvn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out
);

    t_state r_state, n_state;
    logic [7:0]  r_side;
    logic [7:0]  r_seff;
    logic [6:0]  r_i;
    logic [6:0]  r_j;
    logic [1:0]  r_rr;
    logic [1:0]  r_rc;
    logic        r_cap;
    logic [3:0]  r_cidx;
    logic signed [15:0] r_h [9];
    logic [2:0]  r_t;
    t_vec        r_acc;
    logic        r_out_valid;
    t_out        r_out;

    logic [7:0]  s_eff;
    logic        in_grid;
    logic        accept;
    logic        out_free;
    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0] ram_rdata;

    logic signed [15:0] h00, h01, h10, h11;
    logic        r0, c0, second;
    logic        row_ok, col_ok, tri_ok;
    logic signed [16:0] dx, dz;
    logic signed [8:0]  sm1;
    logic signed [25:0] px, pz;
    t_vec        tri_vec;
    t_norm_req   norm_req;
    t_vec        norm_in;
    logic        norm_done;
    t_vec        norm_out;

    always_comb begin
        if (r_side < SIDE_MIN) begin
            s_eff = SIDE_MIN;
        end else if (r_side > SIDE_MAX) begin
            s_eff = SIDE_MAX;
        end else begin
            s_eff = r_side;
        end
        in_grid  = ({1'b0, i_in.row} < s_eff) && ({1'b0, i_in.col} < s_eff);
        out_free = !r_out_valid || i_out_ready;
        accept   = i_in_valid && o_in_ready;
        ram_we   = accept && in_grid && (i_in.cmd == CMD_WRITE);
        ram_addr = ram_we ? {i_in.row, i_in.col}
                          : {7'(r_i + 7'(r_rr) - 7'd1), 7'(r_j + 7'(r_rc) - 7'd1)};
    end

    hvn_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_in.height),
        .o_rdata (ram_rdata)
    );

    // Triangle order: both of the upper-left cell, the first of the upper cell,
    // both of the own cell, the second of the left cell.
    always_comb begin
        case (r_t)
            3'd0: begin h00 = r_h[0]; h01 = r_h[1]; h10 = r_h[3]; h11 = r_h[4];
                        r0 = 1'b0; c0 = 1'b0; second = 1'b0; end
            3'd1: begin h00 = r_h[0]; h01 = r_h[1]; h10 = r_h[3]; h11 = r_h[4];
                        r0 = 1'b0; c0 = 1'b0; second = 1'b1; end
            3'd2: begin h00 = r_h[1]; h01 = r_h[2]; h10 = r_h[4]; h11 = r_h[5];
                        r0 = 1'b0; c0 = 1'b1; second = 1'b0; end
            3'd3: begin h00 = r_h[4]; h01 = r_h[5]; h10 = r_h[7]; h11 = r_h[8];
                        r0 = 1'b1; c0 = 1'b1; second = 1'b0; end
            3'd4: begin h00 = r_h[4]; h01 = r_h[5]; h10 = r_h[7]; h11 = r_h[8];
                        r0 = 1'b1; c0 = 1'b1; second = 1'b1; end
            default: begin h00 = r_h[3]; h01 = r_h[4]; h10 = r_h[6]; h11 = r_h[7];
                        r0 = 1'b1; c0 = 1'b0; second = 1'b1; end
        endcase
        row_ok = r0 ? ((8'(r_i) + 8'd2) <= r_seff) : (r_i != '0);
        col_ok = c0 ? ((8'(r_j) + 8'd2) <= r_seff) : (r_j != '0);
        tri_ok = row_ok && col_ok;
        dx  = second ? (17'(h10) - 17'(h11)) : (17'(h00) - 17'(h01));
        dz  = second ? (17'(h01) - 17'(h11)) : (17'(h00) - 17'(h10));
        sm1 = $signed({1'b0, 8'(r_seff - 8'd1)});
        px  = 26'(dx) * 26'(sm1);
        pz  = 26'(dz) * 26'(sm1);
        tri_vec.x = 32'(px);
        tri_vec.y = 32'({r_seff, 9'd0});
        tri_vec.z = 32'(pz);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept && in_grid && (i_in.cmd == CMD_QUERY)) n_state = S_READ;
            S_READ:  if ((r_rr == 2'd2) && (r_rc == 2'd2)) n_state = S_RWAIT;
            S_RWAIT: n_state = S_TRI;
            S_TRI: begin
                if (r_t == 3'd6) begin
                    n_state = S_VERT;
                end else if (tri_ok) begin
                    n_state = S_TWAIT;
                end
            end
            S_TWAIT: if (norm_done) n_state = S_TRI;
            S_VERT:  n_state = S_VWAIT;
            S_VWAIT: if (norm_done) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == S_IDLE) && out_free;
        norm_req.go   = ((r_state == S_TRI) && (r_t != 3'd6) && tri_ok) || (r_state == S_VERT);
        norm_req.vert = (r_state == S_VERT);
        norm_in       = (r_state == S_VERT) ? r_acc : tri_vec;
        o_out_valid   = r_out_valid;
        o_out         = r_out;
    end

    hvn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (norm_req),
        .i_vec   (norm_in),
        .o_done  (norm_done),
        .o_vec   (norm_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_side      <= SIDE_MAX;
            r_out_valid <= 1'b0;
            r_cap       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cap   <= (r_state == S_READ);
            if (i_cfg_we) begin
                r_side <= i_cfg_wdata;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept && !(in_grid && (i_in.cmd == CMD_QUERY))) begin
                r_out_valid <= 1'b1;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end
        end

        if (accept) begin
            r_i    <= i_in.row;
            r_j    <= i_in.col;
            r_seff <= s_eff;
            r_rr   <= '0;
            r_rc   <= '0;
            r_t    <= '0;
            r_acc  <= '0;
            r_out.normal_x <= '0;
            r_out.normal_y <= '0;
            r_out.normal_z <= '0;
            r_out.status   <= in_grid ? STAT_WRITE : STAT_OUTSIDE;
        end

        if (r_state == S_READ) begin
            if (r_rc == 2'd2) begin
                r_rc <= '0;
                r_rr <= r_rr + 2'd1;
            end else begin
                r_rc <= r_rc + 2'd1;
            end
        end
        r_cidx <= 4'(r_rr) + 4'({r_rr, 1'b0}) + 4'(r_rc);
        // Read data arrives in the cycle after its address.
        if (r_cap) begin
            r_h[r_cidx] <= $signed(ram_rdata);
        end

        if ((r_state == S_TRI) && (r_t != 3'd6) && !tri_ok) begin
            r_t <= r_t + 3'd1;
        end
        if ((r_state == S_TWAIT) && norm_done) begin
            r_acc.x <= r_acc.x + norm_out.x;
            r_acc.y <= r_acc.y + norm_out.y;
            r_acc.z <= r_acc.z + norm_out.z;
            r_t     <= r_t + 3'd1;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out.normal_x <= 16'(norm_out.x);
            r_out.normal_y <= 16'(norm_out.y);
            r_out.normal_z <= 16'(norm_out.z);
            r_out.status   <= STAT_NORMAL;
        end
    end

endmodule
